// ----- design/ttt_pkg.sv -----
package ttt_pkg;

    localparam int TAG_W = 16;
    localparam int OWN_W = 8;
    localparam int STATUS_W = 3;
    localparam int CTR_W = 32;
    localparam int DEF_TAG_COUNT = 256;

    typedef enum logic [STATUS_W-1:0] {
        ST_PENDING = 3'd0,
        ST_NOREPLY = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_STOPPED = 3'd3,
        ST_MATCH   = 3'd4,
        ST_DISCARD = 3'd5
    } status_t;

    typedef enum logic {
        FUNC_ISSUE   = 1'b0,
        FUNC_RECEIVE = 1'b1
    } func_t;

    typedef struct packed {
        logic             rd_en;
        logic             pop;
        logic             push;
        logic [TAG_W-1:0] push_tag;
    } fifo_ctl_t;

    typedef struct packed {
        logic             rd_en;
        logic [TAG_W-1:0] rd_tag;
        logic             wr_en;
        logic [TAG_W-1:0] wr_tag;
        logic             wr_pend;
        logic [OWN_W-1:0] wr_owner;
    } pend_ctl_t;

endpackage

// ----- design/ttt_free_fifo.sv -----
module ttt_free_fifo #(
    parameter int TAG_COUNT = ttt_pkg::DEF_TAG_COUNT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ttt_pkg::fifo_ctl_t        ctl,
    output logic                      empty,
    output logic [ttt_pkg::TAG_W-1:0] rd_tag
);
    import ttt_pkg::*;

    localparam int IDX_W = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;
    localparam int CNT_W = $clog2(TAG_COUNT + 1);
    localparam int SUM_W = IDX_W + 2;

    logic [TAG_W-1:0] mem [TAG_COUNT];
    logic [TAG_W-1:0] mem_q_reg;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    logic [IDX_W:0]   head_inc;
    logic [SUM_W-1:0] tail_sum;
    logic [SUM_W-1:0] tail_mod;
    logic [IDX_W-1:0] tail_idx;
    logic             push_ok;

    assign head_inc = {1'b0, head_reg} + (IDX_W+1)'(1);
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_mod = (tail_sum >= SUM_W'(TAG_COUNT)) ? (tail_sum - SUM_W'(TAG_COUNT)) : tail_sum;
    assign tail_idx = tail_mod[IDX_W-1:0];
    assign push_ok  = ctl.push && (ctl.pop || (count_reg != CNT_W'(TAG_COUNT)));

    assign empty  = (count_reg == '0);
    // slots beyond the fill mark still hold their reset tag
    assign rd_tag = (CNT_W'(head_reg) < fill_reg) ? mem_q_reg : TAG_W'(head_reg);

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        fill_next  = fill_reg;
        if (ctl.pop)
        begin
            head_next = (head_inc == (IDX_W+1)'(TAG_COUNT)) ? '0 : head_inc[IDX_W-1:0];
        end
        if (ctl.pop && !push_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (!ctl.pop && push_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (push_ok && (fill_reg != CNT_W'(TAG_COUNT)))
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= CNT_W'(TAG_COUNT);
            fill_reg  <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[tail_idx] <= ctl.push_tag;
        end
        if (ctl.rd_en)
        begin
            mem_q_reg <= mem[head_reg];
        end
    end

endmodule

// ----- design/ttt_pend_table.sv -----
module ttt_pend_table #(
    parameter int TAG_COUNT = ttt_pkg::DEF_TAG_COUNT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ttt_pkg::pend_ctl_t      ctl,
    output logic                    busy,
    output logic [ttt_pkg::OWN_W:0] rd_q
);
    import ttt_pkg::*;

    localparam int IDX_W = (TAG_COUNT > 1) ? $clog2(TAG_COUNT) : 1;

    logic [OWN_W:0] mem [TAG_COUNT];
    logic [OWN_W:0] mem_q_reg;

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] clr_idx_reg, clr_idx_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [OWN_W:0]   wr_data;

    assign busy = busy_reg;
    assign rd_q = mem_q_reg;

    assign wr_en   = busy_reg || ctl.wr_en;
    assign wr_idx  = busy_reg ? clr_idx_reg : ctl.wr_tag[IDX_W-1:0];
    assign wr_data = busy_reg ? '0 : {ctl.wr_pend, ctl.wr_owner};

    // clearing sweep after reset, one entry per cycle
    always_comb
    begin
        busy_next    = busy_reg;
        clr_idx_next = clr_idx_reg;
        if (busy_reg)
        begin
            if (clr_idx_reg == IDX_W'(TAG_COUNT - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                clr_idx_next = clr_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_idx_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            mem_q_reg <= mem[ctl.rd_tag[IDX_W-1:0]];
        end
    end

endmodule

// ----- design/transaction_tag_tracker_core.sv -----
// the accepting edge registers the item and the memory reads; the update and result
// register follow on the edge where the output register is free or being taken
// a new item is accepted only after the previous one has produced its result; each
// item reads the free-tag fifo and pending table once and updates them as its outcome
// requires when its result is registered; reset: asynchronous, active low; the pending
// table is then swept clear entry by entry, accepting no item meanwhile (cfg writes taken)
module transaction_tag_tracker_core #(
    parameter int TAG_COUNT = ttt_pkg::DEF_TAG_COUNT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         func,
    input  logic                         reply_required,
    input  logic [ttt_pkg::OWN_W-1:0]    requester_id,
    input  logic                         is_command,
    input  logic [ttt_pkg::TAG_W-1:0]    packet_tag,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ttt_pkg::STATUS_W-1:0] status,
    output logic [ttt_pkg::TAG_W-1:0]    tag,
    output logic [ttt_pkg::OWN_W-1:0]    owner_id,
    output logic [ttt_pkg::CTR_W-1:0]    discarded_commands,
    output logic [ttt_pkg::CTR_W-1:0]    unexpected_replies
);
    import ttt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic engine_started_reg;

    logic             func_reg;
    logic             reply_required_reg;
    logic [OWN_W-1:0] requester_id_reg;
    logic             is_command_reg;
    logic [TAG_W-1:0] packet_tag_reg;
    logic             in_range_reg;

    logic             out_valid_reg, out_valid_next;
    status_t          status_reg, status_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic [OWN_W-1:0] owner_reg, owner_next;
    logic [CTR_W-1:0] disc_reg, disc_next;
    logic [CTR_W-1:0] bad_reg, bad_next;

    fifo_ctl_t        fifo_ctl;
    logic             fifo_empty;
    logic [TAG_W-1:0] fifo_tag;
    pend_ctl_t        pend_ctl;
    logic             pend_busy;
    logic [OWN_W:0]   pend_q;

    logic accept;
    logic fire;

    ttt_free_fifo #(
        .TAG_COUNT (TAG_COUNT)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (fifo_ctl),
        .empty  (fifo_empty),
        .rd_tag (fifo_tag)
    );

    ttt_pend_table #(
        .TAG_COUNT (TAG_COUNT)
    ) u_pend (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (pend_ctl),
        .busy  (pend_busy),
        .rd_q  (pend_q)
    );

    assign in_ready = (state_reg == S_IDLE) && !pend_busy;
    assign accept   = in_valid && in_ready;
    assign fire     = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign tag                = tag_reg;
    assign owner_id           = owner_reg;
    assign discarded_commands = disc_reg;
    assign unexpected_replies = bad_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        tag_next       = tag_reg;
        owner_next     = owner_reg;
        disc_next      = disc_reg;
        bad_next       = bad_reg;

        fifo_ctl          = '0;
        fifo_ctl.rd_en    = accept;
        pend_ctl          = '0;
        pend_ctl.rd_en    = accept;
        pend_ctl.rd_tag   = packet_tag;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    tag_next       = '0;
                    owner_next     = '0;
                    if (func_reg == FUNC_ISSUE)
                    begin
                        if (!engine_started_reg)
                        begin
                            status_next = ST_STOPPED;
                        end
                        else if (fifo_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            tag_next     = fifo_tag;
                            fifo_ctl.pop = 1'b1;
                            if (reply_required_reg)
                            begin
                                pend_ctl.wr_en    = 1'b1;
                                pend_ctl.wr_tag   = fifo_tag;
                                pend_ctl.wr_pend  = 1'b1;
                                pend_ctl.wr_owner = requester_id_reg;
                                status_next       = ST_PENDING;
                            end
                            else
                            begin
                                fifo_ctl.push     = 1'b1;
                                fifo_ctl.push_tag = fifo_tag;
                                status_next       = ST_NOREPLY;
                            end
                        end
                    end
                    else if (is_command_reg)
                    begin
                        disc_next   = disc_reg + CTR_W'(1);
                        status_next = ST_DISCARD;
                    end
                    else if (in_range_reg && pend_q[OWN_W])
                    begin
                        owner_next        = pend_q[OWN_W-1:0];
                        tag_next          = packet_tag_reg;
                        pend_ctl.wr_en    = 1'b1;
                        pend_ctl.wr_tag   = packet_tag_reg;
                        fifo_ctl.push     = 1'b1;
                        fifo_ctl.push_tag = packet_tag_reg;
                        status_next       = ST_MATCH;
                    end
                    else
                    begin
                        bad_next    = bad_reg + CTR_W'(1);
                        status_next = ST_DISCARD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            engine_started_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
            disc_reg           <= '0;
            bad_reg            <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            disc_reg      <= disc_next;
            bad_reg       <= bad_next;
            if (cfg_wr_en)
            begin
                engine_started_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg           <= func;
            reply_required_reg <= reply_required;
            requester_id_reg   <= requester_id;
            is_command_reg     <= is_command;
            packet_tag_reg     <= packet_tag;
            in_range_reg       <= ({1'b0, packet_tag} < (TAG_W+1)'(TAG_COUNT));
        end
        status_reg <= status_next;
        tag_reg    <= tag_next;
        owner_reg  <= owner_next;
    end

`ifndef ASSERT_OFF
    a_no_update_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        pend_busy |-> (state_reg == S_IDLE))
        else $error("item in flight during table clear");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_ctl.pop |-> !fifo_empty)
        else $error("pop from empty free-tag fifo");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted item did not enter execute");

    a_result_counts: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (out_valid_reg && ($countones({disc_reg != $past(disc_reg),
                                                bad_reg != $past(bad_reg)}) <= 1)))
        else $error("result missing or both counters moved");
`endif

endmodule

// ----- dv/tb_transaction_tag_tracker_core.sv -----
module tb_transaction_tag_tracker_core;
    import ttt_pkg::*;

    localparam int NTAGS = DEF_TAG_COUNT;

    typedef struct packed {
        func_t            fn;
        logic             rr;
        logic [OWN_W-1:0] rid;
        logic             is_cmd;
        logic [TAG_W-1:0] ptag;
    } tag_event_t;

    typedef struct packed {
        status_t          st;
        logic [TAG_W-1:0] tag;
        logic [OWN_W-1:0] owner;
        logic [CTR_W-1:0] cmds;
        logic [CTR_W-1:0] bads;
    } tag_outcome_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic                cfg_wr_data = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                func = 1'b0;
    logic                reply_required = 1'b0;
    logic [OWN_W-1:0]    requester_id = '0;
    logic                is_command = 1'b0;
    logic [TAG_W-1:0]    packet_tag = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    tag;
    logic [OWN_W-1:0]    owner_id;
    logic [CTR_W-1:0]    discarded_commands;
    logic [CTR_W-1:0]    unexpected_replies;

    // shadow of the tracker state
    logic [TAG_W-1:0] free_tags [NTAGS];
    int unsigned      free_head;
    int unsigned      free_count;
    bit               tag_pending [NTAGS];
    logic [OWN_W-1:0] tag_owner [NTAGS];
    logic [CTR_W-1:0] cmd_discards;
    logic [CTR_W-1:0] bad_replies;
    bit               engine_on;

    tag_event_t   events_to_send[$];
    tag_outcome_t outcomes_due[$];
    tag_event_t   cur_event;
    int           send_idle = 23;
    int           recv_idle = 69;
    bit           hold_off = 1'b0;
    int           n_accepted = 0;
    int           n_queued = 0;
    int           errors = 0;

    transaction_tag_tracker_core #(
        .TAG_COUNT(NTAGS)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .func               (func),
        .reply_required     (reply_required),
        .requester_id       (requester_id),
        .is_command         (is_command),
        .packet_tag         (packet_tag),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .tag                (tag),
        .owner_id           (owner_id),
        .discarded_commands (discarded_commands),
        .unexpected_replies (unexpected_replies)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void release_tag(logic [TAG_W-1:0] t);
        if (free_count < NTAGS)
        begin
            free_tags[(free_head + free_count) % NTAGS] = t;
            free_count++;
        end
    endfunction

    function automatic tag_outcome_t tag_outcome(tag_event_t ev);
        tag_outcome_t r;
        logic [TAG_W-1:0] t;
        r = '0;
        if (ev.fn == FUNC_ISSUE)
        begin
            if (!engine_on)
                r.st = ST_STOPPED;
            else if (free_count == 0)
                r.st = ST_EMPTY;
            else
            begin
                t = free_tags[free_head];
                free_head = (free_head + 1) % NTAGS;
                free_count--;
                r.tag = t;
                if (ev.rr)
                begin
                    tag_pending[t % NTAGS] = 1'b1;
                    tag_owner[t % NTAGS] = ev.rid;
                    r.st = ST_PENDING;
                end
                else
                begin
                    release_tag(t);
                    r.st = ST_NOREPLY;
                end
            end
        end
        else if (ev.is_cmd)
        begin
            cmd_discards++;
            r.st = ST_DISCARD;
        end
        else if (ev.ptag < NTAGS && tag_pending[ev.ptag % NTAGS])
        begin
            r.owner = tag_owner[ev.ptag % NTAGS];
            tag_pending[ev.ptag % NTAGS] = 1'b0;
            release_tag(ev.ptag);
            r.tag = ev.ptag;
            r.st = ST_MATCH;
        end
        else
        begin
            bad_replies++;
            r.st = ST_DISCARD;
        end
        r.cmds = cmd_discards;
        r.bads = bad_replies;
        return r;
    endfunction

    function automatic tag_event_t mk_event(func_t f, logic rr, logic [OWN_W-1:0] rid,
                                            logic ic, logic [TAG_W-1:0] pt);
        tag_event_t ev;
        ev.fn = f;
        ev.rr = rr;
        ev.rid = rid;
        ev.is_cmd = ic;
        ev.ptag = pt;
        return ev;
    endfunction

    task automatic queue_event(tag_event_t ev);
        events_to_send = {events_to_send, ev};
        n_queued++;
    endtask

    // most replies aim at a tag that is currently outstanding
    task automatic gen_events(int n, int issue_pct, int rr_pct);
        tag_event_t ev;
        int k;
        int j;
        int pick;
        int base;
        for (k = 0; k < n; k++)
        begin
            while (events_to_send.size() >= 2)
                @(posedge clk);
            ev.fn = ($urandom_range(99) < issue_pct) ? FUNC_ISSUE : FUNC_RECEIVE;
            ev.rr = ($urandom_range(99) < rr_pct);
            ev.rid = OWN_W'($urandom_range(255));
            ev.is_cmd = ($urandom_range(99) < 10);
            pick = $urandom_range(99);
            if (pick < 15)
                ev.ptag = TAG_W'($urandom_range(65535));
            else
                ev.ptag = TAG_W'($urandom_range(NTAGS - 1));
            if (pick >= 30)
            begin
                base = int'(ev.ptag);
                for (j = 0; j < NTAGS; j++)
                begin
                    if (tag_pending[(base + j) % NTAGS])
                    begin
                        ev.ptag = TAG_W'((base + j) % NTAGS);
                        break;
                    end
                end
            end
            queue_event(ev);
        end
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || outcomes_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_engine(logic v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        engine_on = v;
    endtask

    task automatic check_field(string name, logic [CTR_W-1:0] want, logic [CTR_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        tag_outcome_t due;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                due = tag_outcome(cur_event);
                outcomes_due = {outcomes_due, due};
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (events_to_send.size() != 0 && $urandom_range(99) >= send_idle)
                begin
                    cur_event = events_to_send[0];
                    events_to_send.delete(0);
                    in_valid <= 1'b1;
                    func <= cur_event.fn;
                    reply_required <= cur_event.rr;
                    requester_id <= cur_event.rid;
                    is_command <= cur_event.is_cmd;
                    packet_tag <= cur_event.ptag;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end

    // monitor
    always @(posedge clk)
    begin
        tag_outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (outcomes_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual status %0d tag %0h",
                         $time, status, tag);
                errors++;
            end
            else
            begin
                want = outcomes_due[0];
                outcomes_due.delete(0);
                check_field("status", CTR_W'(want.st), CTR_W'(status));
                check_field("tag", CTR_W'(want.tag), CTR_W'(tag));
                check_field("owner_id", CTR_W'(want.owner), CTR_W'(owner_id));
                check_field("discarded_commands", want.cmds, discarded_commands);
                check_field("unexpected_replies", want.bads, unexpected_replies);
            end
        end
    end

    // long receiver stall while the sender keeps pushing
    initial
    begin
        while (n_accepted < 1300)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int i;
        for (i = 0; i < NTAGS; i++)
        begin
            free_tags[i] = TAG_W'(i);
            tag_pending[i] = 1'b0;
            tag_owner[i] = '0;
        end
        free_head = 0;
        free_count = NTAGS;
        cmd_discards = '0;
        bad_replies = '0;
        engine_on = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // engine stopped
        queue_event(mk_event(FUNC_ISSUE, 1'b1, 8'h5a, 1'b0, 16'h0000));
        queue_event(mk_event(FUNC_ISSUE, 1'b0, 8'hff, 1'b1, 16'hffff));
        queue_event(mk_event(FUNC_RECEIVE, 1'b1, 8'h00, 1'b1, 16'hffff));
        queue_event(mk_event(FUNC_RECEIVE, 1'b0, 8'hff, 1'b0, 16'h0000));
        wait_drained();
        write_engine(1'b1);

        queue_event(mk_event(FUNC_ISSUE, 1'b1, 8'hff, 1'b0, 16'h0000));
        queue_event(mk_event(FUNC_ISSUE, 1'b0, 8'h00, 1'b1, 16'hffff));
        queue_event(mk_event(FUNC_ISSUE, 1'b1, 8'h00, 1'b0, 16'h0002));
        queue_event(mk_event(FUNC_RECEIVE, 1'b0, 8'h00, 1'b0, 16'h0000));
        queue_event(mk_event(FUNC_RECEIVE, 1'b1, 8'hff, 1'b0, 16'h0000));
        queue_event(mk_event(FUNC_RECEIVE, 1'b0, 8'h00, 1'b0, 16'h0100));
        queue_event(mk_event(FUNC_RECEIVE, 1'b0, 8'h00, 1'b0, 16'hffff));
        queue_event(mk_event(FUNC_RECEIVE, 1'b0, 8'h00, 1'b1, 16'h0002));
        queue_event(mk_event(FUNC_RECEIVE, 1'b1, 8'haa, 1'b0, 16'h0002));
        queue_event(mk_event(FUNC_ISSUE, 1'b1, 8'h81, 1'b1, 16'h0003));
        queue_event(mk_event(FUNC_RECEIVE, 1'b0, 8'h7e, 1'b0, 16'h0003));

        gen_events(250, 45, 80);
        // drain the pool until issues run dry
        gen_events(300, 98, 95);
        wait_drained();

        send_idle = 69;
        recv_idle = 23;
        write_engine(1'b0);
        gen_events(100, 60, 80);
        wait_drained();
        write_engine(1'b1);
        gen_events(450, 55, 70);

        send_idle = 0;
        recv_idle = 0;
        gen_events(250, 98, 95);
        gen_events(300, 40, 80);
        wait_drained();
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
